// ----- hw/rtl/calendar_date_arithmetic_unit_defines.svh -----
// assertion macros for the calendar date arithmetic unit
`ifndef CALENDAR_DATE_ARITHMETIC_UNIT_DEFINES_SVH
`define CALENDAR_DATE_ARITHMETIC_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, off during reset
`define CDAU_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define CDAU_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CDAU_ASSERT_IMPL(name, clk, rstn, ante, cons, msg)
`define CDAU_ASSERT_NEXT(name, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/cdau_pkg.sv -----
// types, constants, microcode table and calendar helpers
`default_nettype none

package cdau_pkg;

  localparam int MAX_OFFSET_DEF = 4095;
  localparam int MAX_YEAR_DEF   = 9999;
  localparam int YEAR_CAP       = 16383;

  localparam logic [21:0] DIFF_MAX = 22'h3FFFFF;

  localparam int ADDR_W = 5;

  // mode codes
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_ADD  = 2'd1;
  localparam logic [1:0] MODE_SUB  = 2'd2;
  localparam logic [1:0] MODE_CMP  = 2'd3;

  // order codes
  localparam logic [1:0] ORD_EQ      = 2'd0;
  localparam logic [1:0] ORD_EARLIER = 2'd1;
  localparam logic [1:0] ORD_LATER   = 2'd2;

  // microcode addresses
  localparam logic [ADDR_W-1:0] UA_IDLE     = 5'd0;
  localparam logic [ADDR_W-1:0] UA_LD_Q     = 5'd1;
  localparam logic [ADDR_W-1:0] UA_LD_REM   = 5'd2;
  localparam logic [ADDR_W-1:0] UA_LD_CHK   = 5'd3;
  localparam logic [ADDR_W-1:0] UA_ADD_INIT = 5'd4;
  localparam logic [ADDR_W-1:0] UA_ADD_STEP = 5'd5;
  localparam logic [ADDR_W-1:0] UA_ADD_DONE = 5'd6;
  localparam logic [ADDR_W-1:0] UA_SUB_INIT = 5'd7;
  localparam logic [ADDR_W-1:0] UA_SUB_STEP = 5'd8;
  localparam logic [ADDR_W-1:0] UA_SUB_DONE = 5'd9;
  localparam logic [ADDR_W-1:0] UA_A_INIT   = 5'd10;
  localparam logic [ADDR_W-1:0] UA_A_MUL    = 5'd11;
  localparam logic [ADDR_W-1:0] UA_A_Q100   = 5'd12;
  localparam logic [ADDR_W-1:0] UA_A_Q400   = 5'd13;
  localparam logic [ADDR_W-1:0] UA_A_ADDQ   = 5'd14;
  localparam logic [ADDR_W-1:0] UA_B_INIT   = 5'd15;
  localparam logic [ADDR_W-1:0] UA_B_MUL    = 5'd16;
  localparam logic [ADDR_W-1:0] UA_B_Q100   = 5'd17;
  localparam logic [ADDR_W-1:0] UA_B_Q400   = 5'd18;
  localparam logic [ADDR_W-1:0] UA_B_ADDQ   = 5'd19;
  localparam logic [ADDR_W-1:0] UA_DIFF     = 5'd20;
  localparam logic [ADDR_W-1:0] UA_OUT      = 5'd21;
  localparam logic [ADDR_W-1:0] UA_RET      = 5'd22;

  typedef enum logic [3:0] {
    OP_NOP, OP_LD_Q, OP_LD_REM, OP_LD_CHK,
    OP_ADD_INIT, OP_ADD_STEP, OP_SUB_INIT, OP_SUB_STEP,
    OP_COMMIT, OP_RD_INIT, OP_RD_MUL, OP_RD_Q100,
    OP_RD_Q400, OP_RD_ADDQ, OP_DIFF, OP_OUT
  } uop_t;

  typedef enum logic [2:0] {
    COND_NEVER, COND_ALWAYS, COND_ADD_MORE, COND_SUB_MORE, COND_BUSY
  } cond_t;

  typedef struct packed {
    uop_t              op;
    cond_t             cond;
    logic [ADDR_W-1:0] target;
    logic              sel_arg;
  } ctrl_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] day_count;
    logic [4:0]  arg_day;
    logic [3:0]  arg_month;
    logic [13:0] arg_year;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [21:0] day_difference;
    logic [1:0]  order;
    logic        error;
  } out_word_t;

  function automatic ctrl_t uc_word(input logic [ADDR_W-1:0] addr);
    ctrl_t w;
    w = '{op: OP_NOP, cond: COND_NEVER, target: UA_IDLE, sel_arg: 1'b0};
    unique case (addr)
      UA_IDLE:     w.op = OP_NOP;
      UA_LD_Q:     w.op = OP_LD_Q;
      UA_LD_REM:   w.op = OP_LD_REM;
      UA_LD_CHK:   w = '{op: OP_LD_CHK, cond: COND_ALWAYS, target: UA_OUT, sel_arg: 1'b0};
      UA_ADD_INIT: w.op = OP_ADD_INIT;
      UA_ADD_STEP: w = '{op: OP_ADD_STEP, cond: COND_ADD_MORE, target: UA_ADD_STEP,
                         sel_arg: 1'b0};
      UA_ADD_DONE: w = '{op: OP_COMMIT, cond: COND_ALWAYS, target: UA_OUT, sel_arg: 1'b0};
      UA_SUB_INIT: w.op = OP_SUB_INIT;
      UA_SUB_STEP: w = '{op: OP_SUB_STEP, cond: COND_SUB_MORE, target: UA_SUB_STEP,
                         sel_arg: 1'b0};
      UA_SUB_DONE: w = '{op: OP_COMMIT, cond: COND_ALWAYS, target: UA_OUT, sel_arg: 1'b0};
      UA_A_INIT:   w.op = OP_RD_INIT;
      UA_A_MUL:    w.op = OP_RD_MUL;
      UA_A_Q100:   w.op = OP_RD_Q100;
      UA_A_Q400:   w.op = OP_RD_Q400;
      UA_A_ADDQ:   w.op = OP_RD_ADDQ;
      UA_B_INIT:   w = '{op: OP_RD_INIT, cond: COND_NEVER, target: UA_IDLE, sel_arg: 1'b1};
      UA_B_MUL:    w.op = OP_RD_MUL;
      UA_B_Q100:   w.op = OP_RD_Q100;
      UA_B_Q400:   w.op = OP_RD_Q400;
      UA_B_ADDQ:   w.op = OP_RD_ADDQ;
      UA_DIFF:     w.op = OP_DIFF;
      UA_OUT:      w = '{op: OP_OUT, cond: COND_BUSY, target: UA_OUT, sel_arg: 1'b0};
      UA_RET:      w = '{op: OP_NOP, cond: COND_ALWAYS, target: UA_IDLE, sel_arg: 1'b0};
      default:     w = '{op: OP_NOP, cond: COND_ALWAYS, target: UA_IDLE, sel_arg: 1'b0};
    endcase
    return w;
  endfunction

  function automatic logic [ADDR_W-1:0] mode_entry(input logic [1:0] mode);
    logic [ADDR_W-1:0] a;
    unique case (mode)
      MODE_LOAD: a = UA_LD_Q;
      MODE_ADD:  a = UA_ADD_INIT;
      MODE_SUB:  a = UA_SUB_INIT;
      MODE_CMP:  a = UA_A_INIT;
      default:   a = UA_IDLE;
    endcase
    return a;
  endfunction

  // leap test from year mod 400
  function automatic logic is_leap(input logic [8:0] r400);
    return (r400[1:0] == 2'd0) && (r400 != 9'd100) && (r400 != 9'd200) &&
           (r400 != 9'd300);
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    unique case (m)
      4'd2:                      n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
      default:                   n = 5'd31;
    endcase
    return n;
  endfunction

  // (153*m - 457)/5 with january and february counted as months 13 and 14
  function automatic logic [8:0] month_term(input logic [3:0] m);
    logic [8:0] t;
    unique case (m)
      4'd0:    t = 9'd275;
      4'd1:    t = 9'd306;
      4'd2:    t = 9'd337;
      4'd3:    t = 9'd0;
      4'd4:    t = 9'd31;
      4'd5:    t = 9'd61;
      4'd6:    t = 9'd92;
      4'd7:    t = 9'd122;
      4'd8:    t = 9'd153;
      4'd9:    t = 9'd184;
      4'd10:   t = 9'd214;
      4'd11:   t = 9'd245;
      4'd12:   t = 9'd275;
      4'd13:   t = 9'd306;
      4'd14:   t = 9'd337;
      4'd15:   t = 9'd367;
      default: t = 9'd0;
    endcase
    return t;
  endfunction

  // x/25 by reciprocal, exact for x below 4681
  function automatic logic [7:0] q25(input logic [11:0] x);
    logic [23:0] p;
    p = 24'(x) * 24'd2622;
    return p[23:16];
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/cdau_if.sv -----
// valid/ready channel interfaces for input and result words
`default_nettype none

interface cdau_in_if import cdau_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cdau_out_if import cdau_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/calendar_date_arithmetic_unit.sv -----
// calendar date register with day add/subtract and day difference, microcoded
//
//   channel   dir  handshake     word
//   in_chan   in   valid/ready   mode, day_count, arg_day, arg_month, arg_year
//   out_chan  out  valid/ready   day, month, year, day_difference, order, error
//
// one word at a time; in_chan.ready is high only while the sequencer idles
// load and compare run straight-line microcode; add/subtract steps one month at
// a time through the month-step loop of the shared datapath
// the result sits in an output register; a stalled out_chan holds the sequencer
// synchronous active-low reset sets the date to 0001-01-01, no clearing pass
`default_nettype none
`include "calendar_date_arithmetic_unit_defines.svh"

module calendar_date_arithmetic_unit import cdau_pkg::*; #(
  parameter int MAX_OFFSET = MAX_OFFSET_DEF,
  parameter int MAX_YEAR   = MAX_YEAR_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  cdau_in_if.sink     in_chan,
  cdau_out_if.source  out_chan
);

  localparam int          YEAR_LIMIT = (MAX_YEAR < YEAR_CAP) ? MAX_YEAR : YEAR_CAP;
  localparam logic [13:0] YEAR_MAX   = 14'(YEAR_LIMIT);
  localparam logic [16:0] OFFSET_LIM = 17'(MAX_OFFSET);

  logic [ADDR_W-1:0]  pc_r, pc_nxt;
  logic [4:0]         cur_day_r, cur_day_nxt;
  logic [3:0]         cur_month_r, cur_month_nxt;
  logic [13:0]        cur_year_r, cur_year_nxt;
  logic [8:0]         cur_r400_r, cur_r400_nxt;
  in_word_t           arg_r, arg_nxt;
  logic signed [13:0] d_r, d_nxt;
  logic [3:0]         m_r, m_nxt;
  logic [13:0]        y_r, y_nxt;
  logic [8:0]         r_r, r_nxt;
  logic signed [14:0] ys_r, ys_nxt;
  logic signed [23:0] acc_r, acc_nxt;
  logic signed [23:0] rda_r, rda_nxt;
  logic [7:0]         q_r, q_nxt;
  logic               err_r, err_nxt;
  logic [21:0]        diff_r, diff_nxt;
  logic [1:0]         order_r, order_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r, out_word_nxt;

  ctrl_t              uc;
  logic               in_acc;
  logic               out_busy;
  logic               cond_hit;
  logic [11:0]        cnt_sat;
  logic [4:0]         dim_w;
  logic               add_need, add_ovf;
  logic               sub_need, sub_ovf;
  logic [3:0]         sub_m;
  logic [8:0]         sub_r;
  logic [4:0]         sub_dim;
  logic [8:0]         r_inc;
  logic [13:0]        ysp;
  logic [11:0]        q_in;
  logic [7:0]         q_out;
  logic [16:0]        rem_prod, rem_w;
  logic               ld_ok;
  logic [4:0]         dsel;
  logic [3:0]         msel;
  logic [13:0]        ysel;
  logic signed [14:0] yadj;
  logic signed [23:0] acc_init;
  logic signed [23:0] mul365;
  logic signed [23:0] dif;
  logic [23:0]        absd;

  assign uc       = uc_word(pc_r);
  assign in_chan.ready = (pc_r == UA_IDLE);
  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_busy = out_valid_r && !out_chan.ready;

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_word_r;

  assign cnt_sat = ({5'd0, in_chan.data.day_count} > OFFSET_LIM) ? OFFSET_LIM[11:0]
                                                                 : in_chan.data.day_count;

  // month stepping
  assign dim_w    = days_in(m_r, is_leap(r_r));
  assign add_need = d_r > $signed({9'd0, dim_w});
  assign add_ovf  = add_need && (m_r == 4'd12) && (y_r == YEAR_MAX);
  assign r_inc    = (r_r == 9'd399) ? 9'd0 : r_r + 9'd1;
  assign sub_need = d_r < 14'sd1;
  assign sub_ovf  = sub_need && (m_r == 4'd1) && (y_r <= 14'd1);
  assign sub_m    = (m_r == 4'd1) ? 4'd12 : m_r - 4'd1;
  assign sub_r    = (m_r != 4'd1) ? r_r : ((r_r == 9'd0) ? 9'd399 : r_r - 9'd1);
  assign sub_dim  = days_in(sub_m, is_leap(sub_r));

  // shared divide-by-25 unit
  assign ysp = ys_r[14] ? 14'd0 : ys_r[13:0];
  always_comb begin
    unique case (uc.op)
      OP_LD_Q:    q_in = {2'd0, arg_r.arg_year[13:4]};
      OP_RD_Q100: q_in = ysp[13:2];
      OP_RD_Q400: q_in = {2'd0, ysp[13:4]};
      default:    q_in = 12'd0;
    endcase
  end
  assign q_out = q25(q_in);

  // load check
  assign rem_prod = 17'(q_r) * 17'd400;
  assign rem_w    = {3'd0, arg_r.arg_year} - rem_prod;
  assign ld_ok = (arg_r.arg_month >= 4'd1) && (arg_r.arg_month <= 4'd12) &&
                 (arg_r.arg_year >= 14'd1) && (arg_r.arg_year <= YEAR_MAX) &&
                 (arg_r.arg_day >= 5'd1) &&
                 (arg_r.arg_day <= days_in(arg_r.arg_month, is_leap(r_r)));

  // day number terms
  assign dsel     = uc.sel_arg ? arg_r.arg_day : cur_day_r;
  assign msel     = uc.sel_arg ? arg_r.arg_month : cur_month_r;
  assign ysel     = uc.sel_arg ? arg_r.arg_year : cur_year_r;
  assign yadj     = $signed({1'b0, ysel}) - $signed({14'd0, (msel < 4'd3)});
  assign acc_init = $signed({15'd0, month_term(msel)}) + $signed({19'd0, dsel}) - 24'sd306;
  assign mul365   = $signed({{9{ys_r[14]}}, ys_r}) * 24'sd365;
  assign dif      = rda_r - acc_r;
  assign absd     = dif[23] ? 24'(-dif) : 24'(dif);

  always_comb begin
    unique case (uc.cond)
      COND_NEVER:    cond_hit = 1'b0;
      COND_ALWAYS:   cond_hit = 1'b1;
      COND_ADD_MORE: cond_hit = add_need && !add_ovf;
      COND_SUB_MORE: cond_hit = sub_need && !sub_ovf;
      COND_BUSY:     cond_hit = out_busy;
      default:       cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt        = pc_r;
    cur_day_nxt   = cur_day_r;
    cur_month_nxt = cur_month_r;
    cur_year_nxt  = cur_year_r;
    cur_r400_nxt  = cur_r400_r;
    arg_nxt       = arg_r;
    d_nxt         = d_r;
    m_nxt         = m_r;
    y_nxt         = y_r;
    r_nxt         = r_r;
    ys_nxt        = ys_r;
    acc_nxt       = acc_r;
    rda_nxt       = rda_r;
    q_nxt         = q_r;
    err_nxt       = err_r;
    diff_nxt      = diff_r;
    order_nxt     = order_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;

    if (pc_r == UA_IDLE) begin
      if (in_acc) begin
        arg_nxt           = in_chan.data;
        arg_nxt.day_count = cnt_sat;
        err_nxt           = 1'b0;
        diff_nxt          = 22'd0;
        order_nxt         = ORD_EQ;
        pc_nxt            = mode_entry(in_chan.data.mode);
      end
    end else begin
      pc_nxt = cond_hit ? uc.target : pc_r + 5'd1;
    end

    unique case (uc.op)
      OP_NOP: begin
      end
      OP_LD_Q: begin
        q_nxt = q_out;
      end
      OP_LD_REM: begin
        r_nxt = rem_w[8:0];
      end
      OP_LD_CHK: begin
        if (ld_ok) begin
          cur_day_nxt   = arg_r.arg_day;
          cur_month_nxt = arg_r.arg_month;
          cur_year_nxt  = arg_r.arg_year;
          cur_r400_nxt  = r_r;
        end else begin
          err_nxt = 1'b1;
        end
      end
      OP_ADD_INIT: begin
        d_nxt = $signed({9'd0, cur_day_r}) + $signed({2'd0, arg_r.day_count});
        m_nxt = cur_month_r;
        y_nxt = cur_year_r;
        r_nxt = cur_r400_r;
      end
      OP_ADD_STEP: begin
        if (add_ovf) begin
          err_nxt = 1'b1;
        end else if (add_need) begin
          d_nxt = d_r - $signed({9'd0, dim_w});
          if (m_r == 4'd12) begin
            m_nxt = 4'd1;
            y_nxt = y_r + 14'd1;
            r_nxt = r_inc;
          end else begin
            m_nxt = m_r + 4'd1;
          end
        end
      end
      OP_SUB_INIT: begin
        d_nxt = $signed({9'd0, cur_day_r}) - $signed({2'd0, arg_r.day_count});
        m_nxt = cur_month_r;
        y_nxt = cur_year_r;
        r_nxt = cur_r400_r;
      end
      OP_SUB_STEP: begin
        if (sub_ovf) begin
          err_nxt = 1'b1;
        end else if (sub_need) begin
          d_nxt = d_r + $signed({9'd0, sub_dim});
          m_nxt = sub_m;
          r_nxt = sub_r;
          y_nxt = (m_r == 4'd1) ? y_r - 14'd1 : y_r;
        end
      end
      OP_COMMIT: begin
        if (!err_r) begin
          cur_day_nxt   = d_r[4:0];
          cur_month_nxt = m_r;
          cur_year_nxt  = y_r;
          cur_r400_nxt  = r_r;
        end
      end
      OP_RD_INIT: begin
        ys_nxt  = yadj;
        acc_nxt = acc_init;
        if (uc.sel_arg) begin
          rda_nxt = acc_r;
        end
      end
      OP_RD_MUL: begin
        acc_nxt = acc_r + mul365 + $signed({12'd0, ysp[13:2]});
      end
      OP_RD_Q100: begin
        q_nxt = q_out;
      end
      OP_RD_Q400: begin
        acc_nxt = acc_r - $signed({16'd0, q_r});
        q_nxt   = q_out;
      end
      OP_RD_ADDQ: begin
        acc_nxt = acc_r + $signed({16'd0, q_r});
      end
      OP_DIFF: begin
        diff_nxt = (absd > {2'd0, DIFF_MAX}) ? DIFF_MAX : absd[21:0];
        if (rda_r == acc_r) begin
          order_nxt = ORD_EQ;
        end else if (rda_r < acc_r) begin
          order_nxt = ORD_EARLIER;
        end else begin
          order_nxt = ORD_LATER;
        end
      end
      OP_OUT: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{day: cur_day_r, month: cur_month_r, year: cur_year_r,
                            day_difference: diff_r, order: order_r, error: err_r};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= UA_IDLE;
      cur_day_r   <= 5'd1;
      cur_month_r <= 4'd1;
      cur_year_r  <= 14'd1;
      cur_r400_r  <= 9'd1;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      cur_day_r   <= cur_day_nxt;
      cur_month_r <= cur_month_nxt;
      cur_year_r  <= cur_year_nxt;
      cur_r400_r  <= cur_r400_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    arg_r      <= arg_nxt;
    d_r        <= d_nxt;
    m_r        <= m_nxt;
    y_r        <= y_nxt;
    r_r        <= r_nxt;
    ys_r       <= ys_nxt;
    acc_r      <= acc_nxt;
    rda_r      <= rda_nxt;
    q_r        <= q_nxt;
    err_r      <= err_nxt;
    diff_r     <= diff_nxt;
    order_r    <= order_nxt;
    out_word_r <= out_word_nxt;
  end

  `CDAU_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, pc_r != UA_IDLE,
                    "sequencer idle after accept")
  `CDAU_ASSERT_NEXT(a_result_from_out_step, clk, rst_n, uc.op != OP_OUT,
                    !$rose(out_valid_r), "result word without output step")
  `CDAU_ASSERT_IMPL(a_date_valid, clk, rst_n, 1'b1,
                    (cur_month_r >= 4'd1) && (cur_month_r <= 4'd12) &&
                    (cur_day_r != 5'd0) &&
                    (cur_day_r <= days_in(cur_month_r, is_leap(cur_r400_r))) &&
                    (cur_year_r != 14'd0) && (cur_year_r <= YEAR_MAX),
                    "stored date out of range")
  `CDAU_ASSERT_IMPL(a_error_clean, clk, rst_n, out_valid_r && out_word_r.error,
                    (out_word_r.order == ORD_EQ) && (out_word_r.day_difference == 22'd0),
                    "error word carries compare fields")

endmodule

`default_nettype wire
